>>> design/dws_pkg.sv
// Shared types, constants and helpers of the dependency wave scheduler.
// Used by every module of the block; depends on nothing.

package dws_pkg;

    // Task capacity and the widths that follow from it
    localparam int MAX_NODES     = 16;
    localparam int NODE_W        = $clog2(MAX_NODES);
    localparam int CNT_W         = $clog2(MAX_NODES + 1);
    localparam int WAVE_ITER_MAX = MAX_NODES + 2;
    localparam int ITER_W        = $clog2(WAVE_ITER_MAX + 1);
    localparam int CFG_W         = 5;

    // Command codes carried in the func field
    localparam logic [2:0] FUNC_CLEAR      = 3'd0;
    localparam logic [2:0] FUNC_ADD_EDGE   = 3'd1;
    localparam logic [2:0] FUNC_SET_STATUS = 3'd2;
    localparam logic [2:0] FUNC_INIT       = 3'd3;
    localparam logic [2:0] FUNC_ADVANCE    = 3'd4;
    localparam logic [2:0] FUNC_WIDEST     = 3'd5;

    // Task execution status codes
    localparam logic [2:0] ST_WAITING   = 3'd0;
    localparam logic [2:0] ST_EXECUTING = 3'd1;
    localparam logic [2:0] ST_SUCCEEDED = 3'd2;
    localparam logic [2:0] ST_BADDEF    = 3'd3;
    localparam logic [2:0] ST_FAILED    = 3'd4;

    // Configuration register indexes
    localparam logic CFG_USE_STATUS = 1'b0;
    localparam logic CFG_NODE_COUNT = 1'b1;

    typedef struct packed {
        logic [2:0]        func;
        logic [NODE_W-1:0] node_a;
        logic [NODE_W-1:0] node_b;
        logic [2:0]        status_value;
    } t_in_item;

    typedef struct packed {
        logic [MAX_NODES-1:0] frontier;
        logic                 more;
        logic [2:0]           node_status;
        logic [CNT_W-1:0]     widest_wave;
    } t_out_item;

    // Controller to datapath
    typedef struct packed {
        logic load_item;
        logic apply;
        logic wide_step;
        logic scan_step;
        logic adv_end;
        logic wide_end;
        logic load_out;
    } t_dp_cmd;

    // Datapath to controller
    typedef struct packed {
        logic is_advance;
        logic is_widest;
        logic scan_last;
        logic cur_zero;
        logic iter_done;
        logic out_free;
    } t_dp_status;

    // Count set bits of a wave mask
    function automatic logic [CNT_W-1:0] popcount(input logic [MAX_NODES-1:0] v);
        logic [CNT_W-1:0] cnt;
        cnt = '0;
        for (int i = 0; i < MAX_NODES; i++) begin
            cnt = cnt + CNT_W'(v[i]);
        end
        return cnt;
    endfunction

endpackage

>>> design/dws_ctrl.sv
// Sequencer of the dependency wave scheduler: applies each command, and
// scans rows and updates waves for advance and widest. Depends on dws_pkg.

module dws_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  dws_pkg::t_dp_status i_status,
    output dws_pkg::t_dp_cmd    o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_APPLY,
        S_WSTEP,
        S_SCAN,
        S_AEND,
        S_WEND,
        S_DONE
    } t_state;

    t_state r_state;
    t_state n_state;

    // Hold the state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_ready = (r_state == S_IDLE);

    // Decode next state and datapath commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load_item = 1'b1;
                    n_state         = S_APPLY;
                end
            end
            S_APPLY: begin
                o_cmd.apply = 1'b1;
                if (i_status.is_advance) begin
                    n_state = S_SCAN;
                end else if (i_status.is_widest) begin
                    n_state = S_WSTEP;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_WSTEP: begin
                if (i_status.cur_zero || i_status.iter_done) begin
                    n_state = S_DONE;
                end else begin
                    o_cmd.wide_step = 1'b1;
                    n_state         = S_SCAN;
                end
            end
            S_SCAN: begin
                o_cmd.scan_step = 1'b1;
                if (i_status.scan_last) begin
                    n_state = i_status.is_advance ? S_AEND : S_WEND;
                end
            end
            S_AEND: begin
                o_cmd.adv_end = 1'b1;
                n_state       = S_DONE;
            end
            S_WEND: begin
                o_cmd.wide_end = 1'b1;
                n_state        = S_WSTEP;
            end
            S_DONE: begin
                if (i_status.out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

>>> design/dws_datapath.sv
// Datapath of the dependency wave scheduler: graph rows, task status,
// wave masks, row scan accumulator and output register. Depends on dws_pkg.

module dws_datapath (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  dws_pkg::t_in_item                   i_in_item,
    input  logic                                i_cfg_we,
    input  logic                                i_cfg_index,
    input  logic [dws_pkg::CFG_W-1:0]           i_cfg_data,
    input  dws_pkg::t_dp_cmd                    i_cmd,
    output dws_pkg::t_dp_status                 o_status,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output dws_pkg::t_out_item                  o_out_item
);

    localparam int N  = dws_pkg::MAX_NODES;
    localparam int NW = dws_pkg::NODE_W;
    localparam int CW = dws_pkg::CNT_W;
    localparam int IW = dws_pkg::ITER_W;

    // Graph and status store
    logic [N-1:0] r_succ [N];
    logic [N-1:0] r_pred [N];
    logic [2:0]   r_status [N];
    logic [N-1:0] r_wave;
    logic [N-1:0] r_passed;
    logic         r_use_status;
    logic [CW-1:0] r_node_count;
    logic         r_out_valid;

    // Working registers of one command
    dws_pkg::t_in_item  r_item;
    dws_pkg::t_out_item r_out_item;
    logic [N-1:0]  r_cur;
    logic [N-1:0]  r_acc;
    logic [N-1:0]  r_seen;
    logic [NW-1:0] r_idx;
    logic [CW-1:0] r_best;
    logic [IW-1:0] r_iter;

    logic [CW-1:0] w_scope;
    logic [N:0]    w_sm_full;
    logic [N-1:0]  w_sm;
    logic [N-1:0]  w_wait;
    logic [N-1:0]  w_active;
    logic [N-1:0]  w_done;
    logic [N-1:0]  w_ready;
    logic [N-1:0]  w_root;
    logic [N-1:0]  w_init;
    logic [N-1:0]  w_row;
    logic [N-1:0]  w_plain_nxt;
    logic [N-1:0]  w_stat_nxt;
    logic [N-1:0]  w_wide_nxt;
    logic [CW-1:0] w_pop;
    logic          w_a_in;
    logic          w_b_in;
    logic          w_more;

    // Clamp the task count to 1..MAX_NODES and build the scope mask
    always_comb begin
        if (r_node_count == '0) begin
            w_scope = CW'(1);
        end else if (r_node_count > CW'(N)) begin
            w_scope = CW'(N);
        end else begin
            w_scope = r_node_count;
        end
    end

    assign w_sm_full = ({{N{1'b0}}, 1'b1} << w_scope) - {{N{1'b0}}, 1'b1};
    assign w_sm      = w_sm_full[N-1:0];

    // Per-task flags: status classes, roots, and all predecessors succeeded
    always_comb begin
        for (int i = 0; i < N; i++) begin
            w_wait[i]   = (r_status[i] == dws_pkg::ST_WAITING);
            w_active[i] = w_wait[i] || (r_status[i] == dws_pkg::ST_EXECUTING);
            w_done[i]   = (r_status[i] == dws_pkg::ST_SUCCEEDED);
            w_root[i]   = ((r_pred[i] & w_sm) == '0);
        end
        for (int i = 0; i < N; i++) begin
            w_ready[i] = w_active[i] && ((r_pred[i] & w_sm & ~w_done) == '0);
        end
    end

    assign w_init      = w_sm & w_root & (r_use_status ? w_wait : {N{1'b1}});
    assign w_row       = r_succ[r_idx];
    assign w_plain_nxt = r_acc & w_sm & ~r_passed;
    assign w_stat_nxt  = (r_acc & w_sm) | (r_cur & w_active);
    assign w_wide_nxt  = r_acc & w_sm & ~r_seen;
    assign w_pop       = dws_pkg::popcount(r_cur);
    assign w_a_in      = CW'(r_item.node_a) < w_scope;
    assign w_b_in      = CW'(r_item.node_b) < w_scope;

    // More work: a waiting task in status mode, an unpassed task otherwise
    assign w_more = r_use_status ? ((w_wait & w_sm) != '0)
                                 : ((r_passed & w_sm) != w_sm);

    // Status back to the sequencer
    assign o_status.is_advance = (r_item.func == dws_pkg::FUNC_ADVANCE);
    assign o_status.is_widest  = (r_item.func == dws_pkg::FUNC_WIDEST);
    assign o_status.scan_last  = (CW'(r_idx) == (w_scope - CW'(1)));
    assign o_status.cur_zero   = (r_cur == '0);
    assign o_status.iter_done  = (r_iter == IW'(dws_pkg::WAVE_ITER_MAX));
    assign o_status.out_free   = !r_out_valid || i_out_ready;

    // Store: graph, status, masks, registers and output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < N; i++) begin
                r_succ[i]   <= '0;
                r_pred[i]   <= '0;
                r_status[i] <= dws_pkg::ST_WAITING;
            end
            r_wave       <= '0;
            r_passed     <= '0;
            r_use_status <= 1'b0;
            r_node_count <= CW'(N);
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    dws_pkg::CFG_USE_STATUS: r_use_status <= i_cfg_data[0];
                    dws_pkg::CFG_NODE_COUNT: r_node_count <= CW'(i_cfg_data);
                    default: ;
                endcase
            end
            if (i_cmd.apply) begin
                case (r_item.func)
                    dws_pkg::FUNC_CLEAR: begin
                        for (int i = 0; i < N; i++) begin
                            r_succ[i]   <= '0;
                            r_pred[i]   <= '0;
                            r_status[i] <= dws_pkg::ST_WAITING;
                        end
                        r_wave   <= '0;
                        r_passed <= '0;
                    end
                    dws_pkg::FUNC_ADD_EDGE: begin
                        if (w_a_in && w_b_in) begin
                            r_succ[r_item.node_a][r_item.node_b] <= 1'b1;
                            r_pred[r_item.node_b][r_item.node_a] <= 1'b1;
                        end
                    end
                    dws_pkg::FUNC_SET_STATUS: begin
                        if (w_a_in && (r_item.status_value <= dws_pkg::ST_FAILED)) begin
                            r_status[r_item.node_a] <= r_item.status_value;
                        end
                    end
                    dws_pkg::FUNC_INIT: begin
                        r_wave   <= w_init;
                        r_passed <= r_use_status ? '0 : w_init;
                    end
                    default: ;
                endcase
            end
            // Move the frontier to the next wave
            if (i_cmd.adv_end) begin
                if (r_use_status) begin
                    r_wave <= w_stat_nxt;
                end else begin
                    r_wave   <= w_plain_nxt;
                    r_passed <= r_passed | w_plain_nxt;
                end
            end
            // Output valid: set on load, drop when taken
            if (i_cmd.load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Working registers: item, scan, wave walk and output payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_item) begin
            r_item <= i_in_item;
        end
        if (i_cmd.apply) begin
            r_cur  <= r_wave & w_sm;
            r_acc  <= '0;
            r_idx  <= '0;
            r_seen <= '0;
            r_best <= '0;
            r_iter <= '0;
        end
        if (i_cmd.wide_step) begin
            if (w_pop > r_best) begin
                r_best <= w_pop;
            end
            r_acc <= '0;
            r_idx <= '0;
        end
        // Fold one successor row into the accumulator
        if (i_cmd.scan_step) begin
            if (r_cur[r_idx]) begin
                if (o_status.is_widest || !r_use_status) begin
                    r_acc <= r_acc | w_row;
                end else if (w_done[r_idx]) begin
                    r_acc <= r_acc | (w_row & w_ready);
                end
            end
            r_idx <= r_idx + NW'(1);
        end
        if (i_cmd.wide_end) begin
            r_cur  <= w_wide_nxt;
            r_seen <= r_seen | w_wide_nxt;
            r_iter <= r_iter + IW'(1);
        end
        if (i_cmd.load_out) begin
            r_out_item.frontier    <= r_wave;
            r_out_item.more        <= w_more;
            r_out_item.node_status <= r_status[r_item.node_a];
            r_out_item.widest_wave <= o_status.is_widest ? r_best : '0;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

endmodule

>>> design/dependency_wave_scheduler.sv
// Top level of the dependency wave scheduler: sequencer plus datapath.
// Depends on dws_pkg, dws_ctrl and dws_datapath.
//
// Usage:
//   Commands enter on the in channel (valid/ready, payload t_in_item) and
//   each gives exactly one result item on the out channel (valid/ready,
//   payload t_out_item). Two registers on the cfg port (index 0 status mode,
//   index 1 task count) are to be written by the user only while the block is idle;
//   the block itself does not enforce this. One command is worked at a
//   time; ready is high only between commands. Each command is applied
//   and its result then loaded into the output register. Advance first
//   scans the n successor rows in scope (one successor row read per
//   cycle), then moves the frontier. Widest wave takes one row scan and
//   one wave step per non-empty wave walked from the frontier (at most
//   n + 1 waves), n the task count in scope.
//   A finished result sits in the output register; a stalled receiver
//   holds it there and the block waits before loading the next result.
//   Synchronous reset empties the graph, sets all tasks waiting, clears
//   both masks, selects plain mode with 16 tasks in scope.

module dependency_wave_scheduler (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_in_valid,
    output logic                      o_in_ready,
    input  dws_pkg::t_in_item         i_in_item,
    output logic                      o_out_valid,
    input  logic                      i_out_ready,
    output dws_pkg::t_out_item        o_out_item,
    input  logic                      i_cfg_we,
    input  logic                      i_cfg_index,
    input  logic [dws_pkg::CFG_W-1:0] i_cfg_data
);

    dws_pkg::t_dp_cmd    w_cmd;
    dws_pkg::t_dp_status w_status;

    // Sequence each command
    dws_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_status   (w_status),
        .o_cmd      (w_cmd)
    );

    // Hold the graph and compute waves
    dws_datapath u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_item   (i_in_item),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_cmd       (w_cmd),
        .o_status    (w_status),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_item  (o_out_item)
    );

endmodule

>>> design/dws_checker.sv
// Port-level checks of the dependency wave scheduler, bound to the top.
// Depends on dws_pkg and dependency_wave_scheduler.

module dws_checker (
    input logic                      i_clk,
    input logic                      i_rst_n,
    input logic                      i_in_valid,
    input logic                      o_in_ready,
    input logic                      o_out_valid,
    input logic                      i_out_ready,
    input dws_pkg::t_out_item        o_out_item
);

    // One command at a time: ready drops after an accept
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("input accepted while a command is in work");

    // Hold a stalled result
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> (o_out_valid && $stable(o_out_item)))
        else $error("stalled result changed or dropped");

    // Wave width never exceeds the task capacity
    a_widest_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_item.widest_wave <= dws_pkg::CNT_W'(dws_pkg::MAX_NODES)))
        else $error("widest wave out of range");

    // A nonzero wave width needs a nonempty frontier
    a_widest_frontier: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_out_item.widest_wave != '0)) |-> (o_out_item.frontier != '0))
        else $error("widest wave reported from an empty frontier");

endmodule

bind dependency_wave_scheduler dws_checker u_dws_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_item  (o_out_item)
);
